### src/bps_pkg.sv
// Package for the byte pattern search unit: sizes, register map codes,
// pipeline structs and small helper functions. No dependencies.
`default_nettype none

package bps_pkg;

  localparam int unsigned PATTERN_MAX = 64;
  localparam int unsigned PAT_IDX_W   = $clog2(PATTERN_MAX);
  localparam int unsigned FILL_W      = $clog2(PATTERN_MAX + 1);
  localparam int unsigned OFFSET_BITS = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned MATCH_W     = 32;
  localparam int unsigned ADDR_W      = 4;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned REG_IDX_W   = 2;
  localparam int unsigned CNT_W       = 2;

  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FOLD_CASE      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SEARCH_FORWARD = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_START_ADDRESS  = 2'd3;

  localparam logic KIND_PATTERN = 1'b0;
  localparam logic KIND_TEXT    = 1'b1;

  localparam logic [CNT_W-1:0] BUF_FULL = 2'd2;

  typedef struct packed {
    logic                   valid;
    logic                   eof;
    logic [OFFSET_BITS-1:0] offset;
  } stage_t;

  typedef struct packed {
    logic               found;
    logic [MATCH_W-1:0] match_start;
  } result_t;

  // index of the last pattern byte in use; zero length acts as one
  function automatic logic [PAT_IDX_W-1:0] last_index(input logic [LEN_W-1:0] len);
    if (len == '0) begin
      last_index = '0;
    end else if (32'(len) > PATTERN_MAX) begin
      last_index = PAT_IDX_W'(PATTERN_MAX - 1);
    end else begin
      last_index = PAT_IDX_W'(32'(len) - 32'd1);
    end
  endfunction

  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                   input logic en);
    if (en && b >= 8'h61 && b <= 8'h7a) begin
      fold_byte = b - 8'h20;
    end else begin
      fold_byte = b;
    end
  endfunction

endpackage

`default_nettype wire

### src/byte_pattern_search_unit.sv
// Byte pattern search unit: a chain of PATTERN_MAX cells compares each text
// byte against every pattern position at once, shift-and style.
// Throughput: one transaction per cycle, pattern or text, when not stalled.
// An accepted end-of-file byte passes the cell row register, then the result
// buffer, before its result is offered. Input stalls only while the 2-entry
// result buffer backs up. Reset: registers 1,1,1,0; pattern bytes are not cleared.
`default_nettype none

module byte_pattern_search_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bps_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [bps_pkg::DATA_W-1:0]   pwdata,
  output logic      [bps_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         kind_i,
  input  wire logic [bps_pkg::BYTE_W-1:0]   data_byte_i,
  input  wire logic                         end_of_file_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              found_o,
  output logic      [bps_pkg::MATCH_W-1:0]  match_start_o
);
  import bps_pkg::*;

  // configuration
  logic [LEN_W-1:0]   len_q, len_d;
  logic               fold_q, fold_d;
  logic               fwd_q, fwd_d;
  logic [DATA_W-1:0]  start_q, start_d;
  logic               cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_comb begin
    len_d   = len_q;
    fold_d  = fold_q;
    fwd_d   = fwd_q;
    start_d = start_q;
    if (cfg_wr) begin
      case (reg_idx)
        REG_PATTERN_LENGTH: len_d   = pwdata[LEN_W-1:0];
        REG_FOLD_CASE:      fold_d  = pwdata[0];
        REG_SEARCH_FORWARD: fwd_d   = pwdata[0];
        REG_START_ADDRESS:  start_d = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PATTERN_LENGTH: prdata = DATA_W'(len_q);
      REG_FOLD_CASE:      prdata = DATA_W'(fold_q);
      REG_SEARCH_FORWARD: prdata = DATA_W'(fwd_q);
      REG_START_ADDRESS:  prdata = start_q;
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= LEN_W'(1);
      fold_q  <= 1'b1;
      fwd_q   <= 1'b1;
      start_q <= '0;
    end else begin
      len_q   <= len_d;
      fold_q  <= fold_d;
      fwd_q   <= fwd_d;
      start_q <= start_d;
    end
  end

  // input side
  logic                   in_acc, acc_text, acc_pat;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic                   fresh_q, fresh_d;
  stage_t                 s1_q, s1_d;
  logic [BYTE_W-1:0]      text_byte;
  logic [CNT_W-1:0]       buf_cnt;

  assign in_stall_o = (buf_cnt == BUF_FULL) ||
                      ((buf_cnt != '0) && s1_q.valid && s1_q.eof && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign acc_text   = in_acc && (kind_i == KIND_TEXT);
  assign acc_pat    = in_acc && (kind_i == KIND_PATTERN);
  assign text_byte  = fold_byte(data_byte_i, fold_q);

  always_comb begin
    fill_d  = fill_q;
    off_d   = off_q;
    fresh_d = fresh_q;
    s1_d.valid  = acc_text;
    s1_d.eof    = end_of_file_i;
    s1_d.offset = off_q;
    if (acc_pat && (fill_q != FILL_W'(PATTERN_MAX))) begin
      fill_d = fill_q + FILL_W'(1);
    end
    if (acc_text) begin
      fill_d  = '0;
      off_d   = end_of_file_i ? '0 : off_q + OFFSET_BITS'(1);
      fresh_d = end_of_file_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      off_q   <= '0;
      fresh_q <= 1'b1;
      s1_q    <= '0;
    end else begin
      fill_q  <= fill_d;
      off_q   <= off_d;
      fresh_q <= fresh_d;
      s1_q    <= s1_d;
    end
  end

  // cell row; a new file starts with no partial matches
  logic [PATTERN_MAX-1:0] match;
  logic [PATTERN_MAX-1:0] chain_in;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign chain_in[i] = 1'b1;
    end else begin : g_link
      assign chain_in[i] = !fresh_q && match[i-1];
    end
    bps_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (acc_pat && (fill_q == FILL_W'(i))),
      .text_i      (acc_text),
      .pat_byte_i  (data_byte_i),
      .text_byte_i (text_byte),
      .chain_i     (chain_in[i]),
      .chain_o     (match[i])
    );
  end

  // tracker and output
  logic [PAT_IDX_W-1:0] last_idx;
  logic                 res_push;
  result_t              res_data;
  result_t              out_data;

  assign last_idx = last_index(len_q);

  bps_tracker u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stage_i      (s1_q),
    .hit_i        (match[last_idx]),
    .last_idx_i   (last_idx),
    .start_addr_i (OFFSET_BITS'(start_q)),
    .forward_i    (fwd_q),
    .push_o       (res_push),
    .result_o     (res_data)
  );

  bps_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .data_i      (res_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_data),
    .count_o     (buf_cnt)
  );

  assign found_o       = out_data.found;
  assign match_start_o = out_data.match_start;

  a_eof_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_text && end_of_file_i) |=> res_push)
    else $error("end of file without result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(acc_text && end_of_file_i) |=> !res_push)
    else $error("result without end of file");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_pat && (fill_q != FILL_W'(PATTERN_MAX))) |=>
      (fill_q == FILL_W'($past(fill_q) + FILL_W'(1))))
    else $error("pattern fill index did not advance");

endmodule

`default_nettype wire

### src/bps_cell.sv
// One search cell: holds a pattern byte and its partial-match bit, and
// passes the bit to the next cell. Depends on bps_pkg.
`default_nettype none

module bps_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      load_i,
  input  wire logic                      text_i,
  input  wire logic [bps_pkg::BYTE_W-1:0] pat_byte_i,
  input  wire logic [bps_pkg::BYTE_W-1:0] text_byte_i,
  input  wire logic                      chain_i,
  output logic                           chain_o
);
  import bps_pkg::*;

  logic [BYTE_W-1:0] pat_q;
  logic              match_q;
  logic              match_d;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pat_q <= pat_byte_i;
    end
  end

  always_comb begin
    match_d = match_q;
    if (text_i) begin
      match_d = chain_i && (text_byte_i == pat_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign chain_o = match_q;

endmodule

`default_nettype wire

### src/bps_tracker.sv
// Match qualifier: checks a completed match against the start address and
// search direction, keeps the best start, and issues the end-of-file result.
// Depends on bps_pkg.
`default_nettype none

module bps_tracker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire bps_pkg::stage_t                stage_i,
  input  wire logic                           hit_i,
  input  wire logic [bps_pkg::PAT_IDX_W-1:0]  last_idx_i,
  input  wire logic [bps_pkg::OFFSET_BITS-1:0] start_addr_i,
  input  wire logic                           forward_i,
  output logic                                push_o,
  output bps_pkg::result_t                    result_o
);
  import bps_pkg::*;

  logic                   have_q, have_d, have_n;
  logic [OFFSET_BITS-1:0] best_q, best_d, best_n;
  logic [OFFSET_BITS-1:0] start;
  logic                   qualify;

  assign start = stage_i.offset - OFFSET_BITS'(last_idx_i);

  always_comb begin
    qualify = 1'b0;
    if (stage_i.valid && hit_i) begin
      if (forward_i) begin
        qualify = !have_q && (start >= start_addr_i);
      end else begin
        qualify = (start <= start_addr_i);
      end
    end
    have_n = have_q | qualify;
    best_n = qualify ? start : best_q;
    have_d = have_n;
    best_d = best_n;
    if (stage_i.valid && stage_i.eof) begin
      have_d = 1'b0;
      best_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      best_q <= '0;
    end else begin
      have_q <= have_d;
      best_q <= best_d;
    end
  end

  assign push_o               = stage_i.valid && stage_i.eof;
  assign result_o.found       = have_n;
  assign result_o.match_start = have_n ? MATCH_W'(best_n) : '0;

endmodule

`default_nettype wire

### src/bps_out_buf.sv
// Two-entry result buffer between the tracker and the output channel.
// Depends on bps_pkg.
`default_nettype none

module bps_out_buf (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  input  wire bps_pkg::result_t        data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output bps_pkg::result_t             result_o,
  output logic [bps_pkg::CNT_W-1:0]    count_o
);
  import bps_pkg::*;

  result_t           mem_q [2];
  logic              wr_q, wr_d;
  logic              rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign result_o    = mem_q[rd_q];
  assign count_o     = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop ? !rd_q : rd_q;
    cnt_d = cnt_q + CNT_W'(push_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != BUF_FULL))
    else $error("result buffer overflow");

endmodule

`default_nettype wire
